// ----- rtl/core/wgp_pkg.sv -----
// Shared types and constants for the weighted graph propagation unit.
// Depends on nothing; the top level refers to it by scoped names.
`timescale 1ns / 1ps

package wgp_pkg;

   localparam int NODE_W  = 6;
   localparam int CFG_W   = 7;
   localparam int OCC_W   = 32;
   localparam int SEL_W   = 16;
   localparam int WGT_W   = 16;
   localparam int BASE_W  = OCC_W + SEL_W;
   localparam int HALF_W  = BASE_W / 2;
   localparam int PART_W  = HALF_W + WGT_W;
   localparam int PROD_W  = BASE_W + WGT_W;
   localparam int SHIFT   = 30;
   localparam int TERM_W  = PROD_W - SHIFT;
   localparam int SUM_W   = TERM_W + 1;

   typedef enum logic [1:0] {
      CMD_NODE = 2'd0,
      CMD_LINK = 2'd1,
      CMD_STEP = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2,
      STATUS_SAT   = 2'd3
   } status_type;

   typedef enum logic [7:0] {
      S_IDLE     = 8'b0000_0001,
      S_LINK     = 8'b0000_0010,
      S_PREP_RD  = 8'b0000_0100,
      S_PREP_MUL = 8'b0000_1000,
      S_WALK     = 8'b0001_0000,
      S_DRAIN    = 8'b0010_0000,
      S_EMIT_RD  = 8'b0100_0000,
      S_EMIT_OUT = 8'b1000_0000
   } state_type;

   typedef struct packed {
      logic              sat;
      logic [OCC_W-1:0]  value;
   } acc_type;

endpackage

// ----- rtl/core/weighted_graph_propagation_unit.sv -----
// Weighted graph propagation unit: node, link and accumulator memories with a link walk.
// Depends on wgp_pkg for types and constants.
// A node item is answered straight from S_IDLE and a link item passes through S_LINK.
// A step sets up each node in S_PREP_RD and S_PREP_MUL and walks its links, then reports
// each node in S_EMIT_RD and S_EMIT_OUT, held by any output stalls; the accumulator memory port takes one link a cycle.
// Reset is synchronous; it clears the control state and the valid bits and sets node_count to 64.
`timescale 1ns / 1ps

module weighted_graph_propagation_unit #(
   parameter int MAX_NODES      = 64,
   parameter int LINKS_PER_NODE = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [wgp_pkg::CFG_W-1:0]             csr_wr_data,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [1:0]                            req_cmd,
   input  logic [wgp_pkg::NODE_W-1:0]            req_node_index,
   input  logic [wgp_pkg::NODE_W-1:0]            req_dest_node,
   input  logic [wgp_pkg::WGT_W-1:0]             req_link_weight,
   input  logic [wgp_pkg::OCC_W-1:0]             req_occupancy_value,
   input  logic [wgp_pkg::SEL_W-1:0]             req_selection_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [wgp_pkg::NODE_W-1:0]            rsp_out_node,
   output logic [wgp_pkg::OCC_W-1:0]             rsp_out_occupancy,
   output logic [1:0]                            rsp_status,
   output logic                                  rsp_last
);

   localparam int NW        = $clog2(MAX_NODES);
   localparam int LW        = (LINKS_PER_NODE > 1) ? $clog2(LINKS_PER_NODE) : 1;
   localparam int CW        = $clog2(LINKS_PER_NODE + 1);
   localparam int LinkDepth = MAX_NODES * (2 ** LW);
   localparam int CFG_W     = wgp_pkg::CFG_W;
   localparam int OCC_W     = wgp_pkg::OCC_W;
   localparam int HALF_W    = wgp_pkg::HALF_W;

   localparam logic [CFG_W-1:0] NodeMax   = CFG_W'(MAX_NODES);
   localparam logic [CW-1:0]    LinkLimit = CW'(LINKS_PER_NODE);

   // Memories.
   logic [OCC_W-1:0]              occ_mem [MAX_NODES];
   logic [wgp_pkg::SEL_W-1:0]     sel_mem [MAX_NODES];
   logic [CW-1:0]                 cnt_mem [MAX_NODES];
   wgp_pkg::acc_type              acc_mem [MAX_NODES];
   logic [NW-1:0]                 link_dest_mem [LinkDepth];
   logic [wgp_pkg::WGT_W-1:0]     link_weight_mem [LinkDepth];

   logic [OCC_W-1:0]              occ_rd_ff;
   logic [wgp_pkg::SEL_W-1:0]     sel_rd_ff;
   logic [CW-1:0]                 cnt_rd_ff;
   wgp_pkg::acc_type              acc_rd_ff;
   logic [NW-1:0]                 link_dest_rd_ff;
   logic [wgp_pkg::WGT_W-1:0]     link_weight_rd_ff;

   logic [MAX_NODES-1:0]          occ_valid_ff;
   logic [MAX_NODES-1:0]          cnt_valid_ff;
   logic [MAX_NODES-1:0]          acc_valid_ff;

   // Control.
   wgp_pkg::state_type            state_ff, state_in;
   logic [CFG_W-1:0]              node_count_ff;
   logic [CFG_W-1:0]              n_eff;
   logic [CFG_W-1:0]              node_ptr_ff, node_ptr_in;
   logic [CW-1:0]                 link_ptr_ff, link_ptr_in;
   logic [CW-1:0]                 walk_cnt_ff, walk_cnt_in;
   logic [wgp_pkg::BASE_W-1:0]    base_ff;
   logic [wgp_pkg::NODE_W-1:0]    req_node_ff;
   logic [wgp_pkg::NODE_W-1:0]    req_dest_ff;
   logic [wgp_pkg::WGT_W-1:0]     req_weight_ff;

   logic                          req_accept;
   logic                          last_node;
   logic [CFG_W-1:0]              next_ptr;
   logic                          link_issue;
   logic                          node_load;
   logic                          link_store;
   logic                          step_start;
   logic                          emit_fire;
   logic [NW-1:0]                 node_addr;
   logic [NW-1:0]                 req_addr;
   logic [NW-1:0]                 cnt_raddr;
   logic [NW-1:0]                 acc_raddr;
   logic [CW-1:0]                 cnt_cur;
   logic                          link_in_range;
   logic [NW+LW-1:0]              link_waddr;

   // Output register.
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [wgp_pkg::NODE_W-1:0]    rsp_node_ff, rsp_node_in;
   logic [OCC_W-1:0]              rsp_occ_ff, rsp_occ_in;
   wgp_pkg::status_type           rsp_status_ff, rsp_status_in;
   logic                          rsp_last_ff, rsp_last_in;
   logic                          rsp_load;

   // Link pipeline.
   logic                          b_vld_ff;
   logic                          c_vld_ff;
   logic [NW-1:0]                 c_dest_ff;
   logic [wgp_pkg::PART_W-1:0]    c_hi_ff;
   logic [wgp_pkg::PART_W-1:0]    c_lo_ff;
   logic                          d_vld_ff;
   logic [NW-1:0]                 d_dest_ff;
   logic [wgp_pkg::TERM_W-1:0]    d_term_ff;
   wgp_pkg::acc_type              d_acc_ff;
   logic [wgp_pkg::PROD_W-1:0]    c_full;
   wgp_pkg::acc_type              acc_old;
   wgp_pkg::acc_type              acc_new;
   wgp_pkg::acc_type              acc_emit;
   logic [wgp_pkg::SUM_W-1:0]     acc_sum;
   logic                          acc_over;

   logic                          wb1_vld_ff;
   logic [NW-1:0]                 wb1_dest_ff;
   wgp_pkg::acc_type              wb1_val_ff;
   logic                          wb2_vld_ff;
   logic [NW-1:0]                 wb2_dest_ff;
   wgp_pkg::acc_type              wb2_val_ff;

   assign n_eff = (node_count_ff == '0) ? CFG_W'(1) :
                  ((node_count_ff > NodeMax) ? NodeMax : node_count_ff);

   assign req_ready  = (state_ff == wgp_pkg::S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_accept = req_valid && req_ready;

   assign next_ptr  = node_ptr_ff + CFG_W'(1);
   assign last_node = (next_ptr == n_eff);
   assign node_addr = node_ptr_ff[NW-1:0];
   assign req_addr  = req_node_ff[NW-1:0];
   assign cnt_raddr = (state_ff == wgp_pkg::S_IDLE) ? req_node_index[NW-1:0] : node_addr;
   assign acc_raddr = ((state_ff == wgp_pkg::S_EMIT_RD) || (state_ff == wgp_pkg::S_EMIT_OUT))
                      ? node_addr : link_dest_rd_ff;

   assign cnt_cur       = cnt_valid_ff[req_addr] ? cnt_rd_ff : '0;
   assign link_in_range = (CFG_W'(req_node_ff) < n_eff) && (CFG_W'(req_dest_ff) < n_eff);
   assign link_waddr    = {req_addr, cnt_cur[LW-1:0]};
   assign acc_emit      = acc_valid_ff[node_addr] ? acc_rd_ff : '0;

   always_comb begin
      state_in      = state_ff;
      node_ptr_in   = node_ptr_ff;
      link_ptr_in   = link_ptr_ff;
      walk_cnt_in   = walk_cnt_ff;
      link_issue    = 1'b0;
      node_load     = 1'b0;
      link_store    = 1'b0;
      step_start    = 1'b0;
      emit_fire     = 1'b0;
      rsp_load      = 1'b0;
      rsp_node_in   = rsp_node_ff;
      rsp_occ_in    = rsp_occ_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      case (state_ff)
         wgp_pkg::S_IDLE: begin
            if (req_accept) begin
               case (req_cmd)
                  wgp_pkg::CMD_NODE: begin
                     rsp_load    = 1'b1;
                     rsp_node_in = req_node_index;
                     rsp_last_in = 1'b1;
                     if (CFG_W'(req_node_index) < n_eff) begin
                        node_load     = 1'b1;
                        rsp_occ_in    = req_occupancy_value;
                        rsp_status_in = wgp_pkg::STATUS_OK;
                     end else begin
                        rsp_occ_in    = '0;
                        rsp_status_in = wgp_pkg::STATUS_RANGE;
                     end
                  end
                  wgp_pkg::CMD_LINK: begin
                     state_in = wgp_pkg::S_LINK;
                  end
                  wgp_pkg::CMD_STEP: begin
                     step_start  = 1'b1;
                     node_ptr_in = '0;
                     state_in    = wgp_pkg::S_PREP_RD;
                  end
                  default: begin
                  end
               endcase
            end
         end
         wgp_pkg::S_LINK: begin
            rsp_load    = 1'b1;
            rsp_node_in = req_node_ff;
            rsp_occ_in  = '0;
            rsp_last_in = 1'b1;
            if (!link_in_range) begin
               rsp_status_in = wgp_pkg::STATUS_RANGE;
            end else if (cnt_cur >= LinkLimit) begin
               rsp_status_in = wgp_pkg::STATUS_FULL;
            end else begin
               link_store    = 1'b1;
               rsp_status_in = wgp_pkg::STATUS_OK;
            end
            state_in = wgp_pkg::S_IDLE;
         end
         wgp_pkg::S_PREP_RD: begin
            state_in = wgp_pkg::S_PREP_MUL;
         end
         wgp_pkg::S_PREP_MUL: begin
            walk_cnt_in = cnt_valid_ff[node_addr] ? cnt_rd_ff : '0;
            link_ptr_in = '0;
            if (walk_cnt_in != '0) begin
               state_in = wgp_pkg::S_WALK;
            end else if (last_node) begin
               state_in = wgp_pkg::S_DRAIN;
            end else begin
               node_ptr_in = next_ptr;
               state_in    = wgp_pkg::S_PREP_RD;
            end
         end
         wgp_pkg::S_WALK: begin
            link_issue  = 1'b1;
            link_ptr_in = link_ptr_ff + CW'(1);
            if (link_ptr_in == walk_cnt_ff) begin
               if (last_node) begin
                  state_in = wgp_pkg::S_DRAIN;
               end else begin
                  node_ptr_in = next_ptr;
                  state_in    = wgp_pkg::S_PREP_RD;
               end
            end
         end
         wgp_pkg::S_DRAIN: begin
            if (!b_vld_ff && !c_vld_ff && !d_vld_ff) begin
               node_ptr_in = '0;
               state_in    = wgp_pkg::S_EMIT_RD;
            end
         end
         wgp_pkg::S_EMIT_RD: begin
            state_in = wgp_pkg::S_EMIT_OUT;
         end
         wgp_pkg::S_EMIT_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               emit_fire     = 1'b1;
               rsp_load      = 1'b1;
               rsp_node_in   = node_ptr_ff[wgp_pkg::NODE_W-1:0];
               rsp_occ_in    = acc_emit.value;
               rsp_status_in = acc_emit.sat ? wgp_pkg::STATUS_SAT : wgp_pkg::STATUS_OK;
               rsp_last_in   = last_node;
               if (last_node) begin
                  state_in = wgp_pkg::S_IDLE;
               end else begin
                  node_ptr_in = next_ptr;
                  state_in    = wgp_pkg::S_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = wgp_pkg::S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= wgp_pkg::S_IDLE;
         node_count_ff <= CFG_W'(64);
         node_ptr_ff   <= '0;
         link_ptr_ff   <= '0;
         walk_cnt_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
         occ_valid_ff  <= '0;
         cnt_valid_ff  <= '0;
         acc_valid_ff  <= '0;
         b_vld_ff      <= 1'b0;
         c_vld_ff      <= 1'b0;
         d_vld_ff      <= 1'b0;
         wb1_vld_ff    <= 1'b0;
         wb2_vld_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         node_ptr_ff  <= node_ptr_in;
         link_ptr_ff  <= link_ptr_in;
         walk_cnt_ff  <= walk_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         b_vld_ff     <= link_issue;
         c_vld_ff     <= b_vld_ff && (CFG_W'(link_dest_rd_ff) < n_eff);
         d_vld_ff     <= c_vld_ff;
         if (csr_wr_en) begin
            node_count_ff <= csr_wr_data;
         end
         if (node_load) begin
            occ_valid_ff[req_node_index[NW-1:0]] <= 1'b1;
            cnt_valid_ff[req_node_index[NW-1:0]] <= 1'b0;
         end
         if (link_store) begin
            cnt_valid_ff[req_addr] <= 1'b1;
         end
         if (emit_fire) begin
            occ_valid_ff[node_addr] <= 1'b1;
         end
         if (step_start) begin
            acc_valid_ff <= '0;
            wb1_vld_ff   <= 1'b0;
            wb2_vld_ff   <= 1'b0;
         end else if (d_vld_ff) begin
            acc_valid_ff[d_dest_ff] <= 1'b1;
            wb1_vld_ff              <= 1'b1;
            wb2_vld_ff              <= wb1_vld_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_node_ff   <= req_node_index;
         req_dest_ff   <= req_dest_node;
         req_weight_ff <= req_link_weight;
      end
      if (rsp_load) begin
         rsp_node_ff   <= rsp_node_in;
         rsp_occ_ff    <= rsp_occ_in;
         rsp_status_ff <= rsp_status_in;
         rsp_last_ff   <= rsp_last_in;
      end
      if (state_ff == wgp_pkg::S_PREP_MUL) begin
         base_ff <= (occ_valid_ff[node_addr] ? occ_rd_ff : '0) * sel_rd_ff;
      end
   end

   // Node tables.
   always_ff @(posedge clock) begin
      if (node_load) begin
         occ_mem[req_node_index[NW-1:0]] <= req_occupancy_value;
         sel_mem[req_node_index[NW-1:0]] <= req_selection_value;
      end else if (emit_fire) begin
         occ_mem[node_addr] <= acc_emit.value;
      end
      occ_rd_ff <= occ_mem[node_addr];
      sel_rd_ff <= sel_mem[node_addr];
   end

   always_ff @(posedge clock) begin
      if (link_store) begin
         cnt_mem[req_addr] <= cnt_cur + CW'(1);
      end
      cnt_rd_ff <= cnt_mem[cnt_raddr];
   end

   // Link table.
   always_ff @(posedge clock) begin
      if (link_store) begin
         link_dest_mem[link_waddr]   <= req_dest_ff[NW-1:0];
         link_weight_mem[link_waddr] <= req_weight_ff;
      end
      link_dest_rd_ff   <= link_dest_mem[{node_addr, link_ptr_ff[LW-1:0]}];
      link_weight_rd_ff <= link_weight_mem[{node_addr, link_ptr_ff[LW-1:0]}];
   end

   // Product of base and weight, split in two halves of the base.
   always_ff @(posedge clock) begin
      c_dest_ff <= link_dest_rd_ff;
      c_hi_ff   <= base_ff[wgp_pkg::BASE_W-1:HALF_W] * link_weight_rd_ff;
      c_lo_ff   <= base_ff[HALF_W-1:0] * link_weight_rd_ff;
      d_dest_ff <= c_dest_ff;
      d_term_ff <= c_full[wgp_pkg::PROD_W-1:wgp_pkg::SHIFT];
      d_acc_ff  <= acc_rd_ff;
   end

   assign c_full = {c_hi_ff, {HALF_W{1'b0}}} + {{HALF_W{1'b0}}, c_lo_ff};

   // The accumulator read misses the last two writes, so those are forwarded.
   always_comb begin
      if (wb1_vld_ff && (wb1_dest_ff == d_dest_ff)) begin
         acc_old = wb1_val_ff;
      end else if (wb2_vld_ff && (wb2_dest_ff == d_dest_ff)) begin
         acc_old = wb2_val_ff;
      end else if (acc_valid_ff[d_dest_ff]) begin
         acc_old = d_acc_ff;
      end else begin
         acc_old = '0;
      end
      acc_sum       = wgp_pkg::SUM_W'(acc_old.value) + wgp_pkg::SUM_W'(d_term_ff);
      acc_over      = |acc_sum[wgp_pkg::SUM_W-1:OCC_W];
      acc_new.value = acc_over ? {OCC_W{1'b1}} : acc_sum[OCC_W-1:0];
      acc_new.sat   = acc_old.sat | acc_over;
   end

   always_ff @(posedge clock) begin
      if (d_vld_ff) begin
         acc_mem[d_dest_ff] <= acc_new;
         wb1_dest_ff        <= d_dest_ff;
         wb1_val_ff         <= acc_new;
         wb2_dest_ff        <= wb1_dest_ff;
         wb2_val_ff         <= wb1_val_ff;
      end
      acc_rd_ff <= acc_mem[acc_raddr];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_node      = rsp_node_ff;
   assign rsp_out_occupancy = rsp_occ_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

// ----- dv/tb_weighted_graph_propagation_unit.sv -----
// Self-checking testbench for the weighted graph propagation unit: node loads, link appends,
// propagation steps and node count settings, checked against an in-bench graph predictor.
// Depends on wgp_pkg and weighted_graph_propagation_unit.
`timescale 1ns / 1ps

module tb_weighted_graph_propagation_unit;

   localparam int         NODE_SLOTS    = 64;
   localparam int         LINK_SLOTS    = 16;
   localparam logic [1:0] CMD_UNUSED    = 2'd3;
   localparam logic [31:0] OCC_FULL     = 32'hFFFF_FFFF;
   localparam int         SETTLE_CYCLES = 16;
   localparam int         HOLD_CYCLES   = 300;
   localparam int         RUN_LIMIT_NS  = 10_000_000;

   typedef struct {
      logic [1:0]                  cmd;
      logic [wgp_pkg::NODE_W-1:0]  node;
      logic [wgp_pkg::NODE_W-1:0]  dest;
      logic [wgp_pkg::WGT_W-1:0]   weight;
      logic [wgp_pkg::OCC_W-1:0]   occupancy;
      logic [wgp_pkg::SEL_W-1:0]   selection;
   } graph_request_t;

   typedef struct {
      logic [wgp_pkg::NODE_W-1:0]  node;
      logic [wgp_pkg::OCC_W-1:0]   occupancy;
      logic [1:0]                  status;
      logic                        last;
   } node_report_t;

   logic                          clock               = 1'b0;
   logic                          reset               = 1'b1;
   logic                          csr_wr_en           = 1'b0;
   logic [wgp_pkg::CFG_W-1:0]     csr_wr_data         = '0;
   logic                          req_valid           = 1'b0;
   logic                          req_ready;
   logic [1:0]                    req_cmd             = '0;
   logic [wgp_pkg::NODE_W-1:0]    req_node_index      = '0;
   logic [wgp_pkg::NODE_W-1:0]    req_dest_node       = '0;
   logic [wgp_pkg::WGT_W-1:0]     req_link_weight     = '0;
   logic [wgp_pkg::OCC_W-1:0]     req_occupancy_value = '0;
   logic [wgp_pkg::SEL_W-1:0]     req_selection_value = '0;
   logic                          rsp_valid;
   logic                          rsp_ready           = 1'b0;
   logic [wgp_pkg::NODE_W-1:0]    rsp_out_node;
   logic [wgp_pkg::OCC_W-1:0]     rsp_out_occupancy;
   logic [1:0]                    rsp_status;
   logic                          rsp_last;

   logic [6:0]                    model_count;
   logic [wgp_pkg::OCC_W-1:0]     model_occ    [NODE_SLOTS];
   logic [wgp_pkg::SEL_W-1:0]     model_sel    [NODE_SLOTS];
   logic [wgp_pkg::NODE_W-1:0]    model_dest   [NODE_SLOTS][LINK_SLOTS];
   logic [wgp_pkg::WGT_W-1:0]     model_weight [NODE_SLOTS][LINK_SLOTS];
   int                            model_links  [NODE_SLOTS];
   node_report_t                  pending_reports [$];
   int                            error_count = 0;

   logic [6:0]                    drive_count = 7'd64;
   bit                            node_loaded [NODE_SLOTS];
   int                            sent_items  = 0;
   bit                            req_steady  = 1'b0;
   bit                            rsp_steady  = 1'b0;
   int                            hold_off    = 0;

   weighted_graph_propagation_unit DUT (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_cmd             (req_cmd),
      .req_node_index      (req_node_index),
      .req_dest_node       (req_dest_node),
      .req_link_weight     (req_link_weight),
      .req_occupancy_value (req_occupancy_value),
      .req_selection_value (req_selection_value),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_out_node        (rsp_out_node),
      .rsp_out_occupancy   (rsp_out_occupancy),
      .rsp_status          (rsp_status),
      .rsp_last            (rsp_last)
   );

   always #1 clock = ~clock;

   function automatic int effective_count(input logic [6:0] value);
      if (value == 7'd0) return 1;
      if (value > 7'd64) return NODE_SLOTS;
      return int'(value);
   endfunction

   function automatic void clear_graph_model();
      model_count = 7'd64;
      for (int i = 0; i < NODE_SLOTS; i++) begin
         model_occ[i]   = '0;
         model_sel[i]   = '0;
         model_links[i] = 0;
      end
   endfunction

   function automatic void push_report(input logic [5:0] node, input logic [31:0] occupancy,
                                      input logic [1:0] status, input logic last);
      node_report_t report;
      report.node      = node;
      report.occupancy = occupancy;
      report.status    = status;
      report.last      = last;
      pending_reports.push_back(report);
   endfunction

   function automatic void propagate_graph(input graph_request_t rq);
      int          n;
      int          i;
      int          j;
      logic [31:0] acc [NODE_SLOTS];
      bit          sat [NODE_SLOTS];
      logic [63:0] base;
      logic [63:0] sum;
      logic [5:0]  d;
      n = effective_count(model_count);
      case (rq.cmd)
         wgp_pkg::CMD_NODE: begin
            if (rq.node >= n) begin
               push_report(rq.node, '0, wgp_pkg::STATUS_RANGE, 1'b1);
            end else begin
               model_occ[rq.node]   = rq.occupancy;
               model_sel[rq.node]   = rq.selection;
               model_links[rq.node] = 0;
               push_report(rq.node, rq.occupancy, wgp_pkg::STATUS_OK, 1'b1);
            end
         end
         wgp_pkg::CMD_LINK: begin
            if (rq.node >= n || rq.dest >= n) begin
               push_report(rq.node, '0, wgp_pkg::STATUS_RANGE, 1'b1);
            end else if (model_links[rq.node] >= LINK_SLOTS) begin
               push_report(rq.node, '0, wgp_pkg::STATUS_FULL, 1'b1);
            end else begin
               model_dest[rq.node][model_links[rq.node]]   = rq.dest;
               model_weight[rq.node][model_links[rq.node]] = rq.weight;
               model_links[rq.node]++;
               push_report(rq.node, '0, wgp_pkg::STATUS_OK, 1'b1);
            end
         end
         wgp_pkg::CMD_STEP: begin
            for (i = 0; i < n; i++) begin
               acc[i] = '0;
               sat[i] = 1'b0;
            end
            for (i = 0; i < n; i++) begin
               base = model_occ[i] * model_sel[i];
               for (j = 0; j < model_links[i]; j++) begin
                  d = model_dest[i][j];
                  if (d < n) begin
                     sum = acc[d] + ((base * model_weight[i][j]) >> wgp_pkg::SHIFT);
                     if (sum[63:32] != 32'd0) begin
                        sum    = {32'd0, OCC_FULL};
                        sat[d] = 1'b1;
                     end
                     acc[d] = sum[31:0];
                  end
               end
            end
            for (i = 0; i < n; i++) begin
               model_occ[i] = acc[i];
               push_report(i, acc[i], sat[i] ? wgp_pkg::STATUS_SAT : wgp_pkg::STATUS_OK,
                           i == n - 1);
            end
         end
         default: begin
         end
      endcase
   endfunction

   function automatic void check_node_report();
      node_report_t want;
      if (pending_reports.size() == 0) begin
         if (error_count < 10)
            $display("%0t: unexpected result node %0d occupancy %h status %0d last %0b",
                     $time, rsp_out_node, rsp_out_occupancy, rsp_status, rsp_last);
         error_count++;
         return;
      end
      want = pending_reports.pop_front();
      if (rsp_out_node !== want.node || rsp_out_occupancy !== want.occupancy ||
          rsp_status !== want.status || rsp_last !== want.last) begin
         if (error_count < 10)
            $display("%0t: expected node %0d occupancy %h status %0d last %0b, got %0d %h %0d %0b",
                     $time, want.node, want.occupancy, want.status, want.last,
                     rsp_out_node, rsp_out_occupancy, rsp_status, rsp_last);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin : graph_monitor
      graph_request_t seen;
      if (reset) begin
         clear_graph_model();
      end else begin
         if (csr_wr_en) model_count = csr_wr_data;
         if (req_valid && req_ready) begin
            seen.cmd       = req_cmd;
            seen.node      = req_node_index;
            seen.dest      = req_dest_node;
            seen.weight    = req_link_weight;
            seen.occupancy = req_occupancy_value;
            seen.selection = req_selection_value;
            propagate_graph(seen);
         end
         if (rsp_valid && rsp_ready) check_node_report();
      end
   end

   initial begin : result_sink
      int gap;
      forever begin
         gap = rsp_steady ? 0 : $urandom_range(0, 7);
         if (gap > 0 || hold_off > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
            while (hold_off > 0) begin
               @(posedge clock);
               hold_off--;
            end
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   function automatic logic [31:0] random_occupancy();
      return $urandom >> $urandom_range(0, 31);
   endfunction

   function automatic graph_request_t random_request(input logic [1:0] cmd);
      graph_request_t rq;
      rq.cmd       = cmd;
      rq.node      = $urandom_range(0, 63);
      rq.dest      = $urandom_range(0, 63);
      rq.weight    = $urandom_range(0, 65535);
      rq.occupancy = $urandom;
      rq.selection = $urandom_range(0, 65535);
      return rq;
   endfunction

   task automatic send_item(input graph_request_t rq);
      int gap;
      gap = req_steady ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_cmd             <= rq.cmd;
      req_node_index      <= rq.node;
      req_dest_node       <= rq.dest;
      req_link_weight     <= rq.weight;
      req_occupancy_value <= rq.occupancy;
      req_selection_value <= rq.selection;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (rq.cmd != CMD_UNUSED) sent_items++;
   endtask

   task automatic load_node(input int node, input logic [31:0] occupancy,
                            input logic [15:0] selection);
      graph_request_t rq;
      rq           = random_request(wgp_pkg::CMD_NODE);
      rq.node      = node;
      rq.occupancy = occupancy;
      rq.selection = selection;
      if (node < effective_count(drive_count)) node_loaded[node] = 1'b1;
      send_item(rq);
   endtask

   task automatic load_random_node(input int span);
      load_node($urandom_range(0, span - 1), random_occupancy(), $urandom_range(0, 65535));
   endtask

   task automatic add_link(input int source, input int dest, input logic [15:0] weight);
      graph_request_t rq;
      rq        = random_request(wgp_pkg::CMD_LINK);
      rq.node   = source;
      rq.dest   = dest;
      rq.weight = weight;
      send_item(rq);
   endtask

   task automatic run_step();
      send_item(random_request(wgp_pkg::CMD_STEP));
   endtask

   task automatic send_unused();
      send_item(random_request(CMD_UNUSED));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_node_count(input logic [6:0] value);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      drive_count = value;
   endtask

   task automatic test_limits_and_range();
      write_node_count(7'd8);
      load_node(0, OCC_FULL, 16'hFFFF);
      load_node(7, 32'd0, 16'd0);
      load_node(8, OCC_FULL, 16'hFFFF);
      load_node(63, 32'h1234_5678, 16'h4000);
      add_link(0, 0, 16'hFFFF);
      add_link(0, 7, 16'd0);
      add_link(9, 0, 16'h8000);
      add_link(0, 63, 16'h8000);
      send_unused();
      run_step();
   endtask

   task automatic test_table_full();
      write_node_count(7'd64);
      load_node(1, 32'h0001_0000, 16'h4000);
      repeat (LINK_SLOTS) add_link(1, $urandom_range(0, 63), $urandom_range(0, 65535));
      add_link(1, 2, 16'h1000);
      run_step();
      load_node(1, 32'h0002_8000, 16'h2000);
      add_link(1, 5, 16'h8000);
   endtask

   task automatic test_stale_links();
      add_link(0, 40, 16'hFFFF);
      write_node_count(7'd16);
      run_step();
   endtask

   task automatic test_count_clamp();
      write_node_count(7'd0);
      run_step();
      write_node_count(7'd127);
      run_step();
   endtask

   task automatic test_output_stall();
      write_node_count(7'd64);
      req_steady = 1'b1;
      hold_off   = HOLD_CYCLES;
      run_step();
      repeat (6) load_random_node(NODE_SLOTS);
      run_step();
      wait_idle();
      req_steady = 1'b0;
   endtask

   task automatic test_random_traffic(input int amount);
      int target;
      int n;
      int source;
      target = sent_items + amount;
      while (sent_items < target) begin
         case ($urandom_range(0, 7))
            0: write_node_count(7'd1);
            1: write_node_count(7'd2);
            2: write_node_count($urandom_range(3, 15));
            3: write_node_count($urandom_range(16, 63));
            4: write_node_count(7'd64);
            5: write_node_count($urandom_range(65, 127));
            6: write_node_count(7'd0);
            default: write_node_count($urandom_range(1, 127));
         endcase
         n          = effective_count(drive_count);
         req_steady = ($urandom_range(0, 3) == 0);
         rsp_steady = ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(2, 5)) begin
            repeat ($urandom_range(1, 4)) load_random_node(n);
            repeat ($urandom_range(0, 12)) begin
               source = $urandom_range(0, n - 1);
               if ($urandom_range(0, 9) == 0) begin
                  case ($urandom_range(0, 3))
                     0: send_unused();
                     1: begin
                        if (n < NODE_SLOTS) load_random_node(NODE_SLOTS);
                        else send_unused();
                     end
                     2: begin
                        if (n < NODE_SLOTS)
                           add_link($urandom_range(n, 63), $urandom_range(0, 63),
                                    $urandom_range(0, 65535));
                        else send_unused();
                     end
                     default: begin
                        if (n < NODE_SLOTS)
                           add_link(source, $urandom_range(n, 63), $urandom_range(0, 65535));
                        else send_unused();
                     end
                  endcase
               end else if (!node_loaded[source]) begin
                  load_node(source, random_occupancy(), $urandom_range(0, 65535));
               end else begin
                  add_link(source, $urandom_range(0, n - 1), $urandom_range(0, 65535));
               end
            end
            run_step();
            if ($urandom_range(0, 3) == 0) run_step();
         end
      end
      req_steady = 1'b0;
      rsp_steady = 1'b0;
   endtask

   initial begin : test_sequence
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_limits_and_range();
      test_table_full();
      test_stale_links();
      test_count_clamp();
      test_output_stall();
      test_random_traffic(480);
      wait_idle();
      repeat (50) @(posedge clock);
      if (error_count == 0 && pending_reports.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin : run_limit
      #(RUN_LIMIT_NS);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
